/* src/svf_pkg.sv */
package svf_pkg;

    // fixed widths of the filter arithmetic
    localparam int STATE_W    = 32;
    localparam int COEF_W     = 23;
    localparam int GAIN_W     = 20;
    localparam int COEF_FRAC  = 22;
    localparam int GAIN_FRAC  = 16;
    localparam int PROD_W     = 60;                   // product and accumulator width
    localparam int V_W        = PROD_W - COEF_FRAC;   // v1 and v2 width
    localparam int DIFF_W     = 40;                   // 2*v - s before saturation
    localparam int MOP_W      = 24;                   // signed coefficient operand
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 23;

    // defaults handed to the top level parameters
    localparam int CHANNELS_DEF    = 2;
    localparam int SAMPLE_BITS_DEF = 24;

    // register reset values
    localparam logic [COEF_W-1:0] A1_RST   = 23'd2097152;
    localparam logic [COEF_W-1:0] A2_RST   = 23'd1048576;
    localparam logic [COEF_W-1:0] A3_RST   = 23'd1048576;
    localparam logic [GAIN_W-1:0] GAIN_RST = 20'd65536;

    // rounding offsets (half an lsb after the shift)
    localparam logic signed [PROD_W-1:0] RND_COEF = PROD_W'(64'sd1 <<< (COEF_FRAC - 1));
    localparam logic signed [PROD_W-1:0] RND_GAIN = PROD_W'(64'sd1 <<< (GAIN_FRAC - 1));

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_A1   = 2'd0,
        CFG_A2   = 2'd1,
        CFG_A3   = 2'd2,
        CFG_GAIN = 2'd3
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_GAIN,
        S_OUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic sum;
        logic gain;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_stat;

    // saturate a difference to the 32-bit state range
    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [DIFF_W-1:0] v
    );
        logic signed [DIFF_W-1:0] hi;
        logic signed [DIFF_W-1:0] lo;
        hi = DIFF_W'(32'sh7FFFFFFF);
        lo = DIFF_W'(32'sh80000000);
        if (v > hi) begin
            return 32'sh7FFFFFFF;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return STATE_W'(v);
    endfunction

endpackage

/* src/svf_ctrl.sv */
module svf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  svf_pkg::t_stat   i_stat,
    output svf_pkg::t_cmd    o_cmd
);

    svf_pkg::t_state r_state;
    svf_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= svf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            svf_pkg::S_IDLE: begin
                if (i_in_valid) n_state = svf_pkg::S_MUL1;
            end
            svf_pkg::S_MUL1: n_state = svf_pkg::S_MUL2;
            svf_pkg::S_MUL2: n_state = svf_pkg::S_SUM;
            svf_pkg::S_SUM:  n_state = svf_pkg::S_GAIN;
            svf_pkg::S_GAIN: n_state = svf_pkg::S_OUT;
            svf_pkg::S_OUT: begin
                if (i_stat.out_free) n_state = svf_pkg::S_IDLE;
            end
            default: n_state = svf_pkg::S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            svf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            svf_pkg::S_MUL1: o_cmd.mul1 = 1'b1;
            svf_pkg::S_MUL2: o_cmd.mul2 = 1'b1;
            svf_pkg::S_SUM:  o_cmd.sum  = 1'b1;
            svf_pkg::S_GAIN: o_cmd.gain = 1'b1;
            svf_pkg::S_OUT:  o_cmd.out_load = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

/* src/svf_dp.sv */
module svf_dp #(
    parameter int CHANNELS    = svf_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = svf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  svf_pkg::t_cmd                        i_cmd,
    output svf_pkg::t_stat                       o_stat,
    input  logic                                 i_cfg_we,
    input  logic [svf_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [svf_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample,
    input  logic                                 i_channel,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [SAMPLE_BITS-1:0]               o_sample,
    output logic                                 o_channel
);

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW     = svf_pkg::STATE_W;
    localparam int PW     = svf_pkg::PROD_W;
    localparam int VW     = svf_pkg::V_W;
    localparam int DW     = svf_pkg::DIFF_W;
    localparam int MW     = svf_pkg::MOP_W;
    localparam int V3_W   = SW + 1;
    localparam int PA_W   = VW + MW;
    localparam int PB_W   = V3_W + MW;
    localparam logic signed [PW-1:0] Y_HI = PW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] Y_LO = -Y_HI - PW'(1);

    // configuration registers
    logic [svf_pkg::COEF_W-1:0] r_a1;
    logic [svf_pkg::COEF_W-1:0] r_a2;
    logic [svf_pkg::COEF_W-1:0] r_a3;
    logic [svf_pkg::GAIN_W-1:0] r_gain;

    // integrator states per channel
    logic signed [SW-1:0] r_int1 [CHANNELS];
    logic signed [SW-1:0] r_int2 [CHANNELS];

    // working registers of one sample
    logic [CH_W-1:0]        r_idx;
    logic                   r_ok;
    logic                   r_ch;
    logic signed [SW-1:0]   r_s1;
    logic signed [SW-1:0]   r_s2;
    logic signed [V3_W-1:0] r_v3;
    logic signed [PW-1:0]   r_pa;
    logic signed [PW-1:0]   r_pb;
    logic signed [VW-1:0]   r_v1;
    logic signed [VW-1:0]   r_v2;

    // output register
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_sample;
    logic                   r_out_ch;

    logic [CH_W-1:0]        w_in_idx;
    logic                   w_in_ok;
    logic signed [VW-1:0]   w_ma;
    logic signed [MW-1:0]   w_mb;
    logic signed [MW-1:0]   w_mc;
    logic signed [PA_W-1:0] w_pa;
    logic signed [PB_W-1:0] w_pb;
    logic signed [PW-1:0]   w_v1_sum;
    logic signed [PW-1:0]   w_v2_sum;
    logic signed [DW-1:0]   w_d1;
    logic signed [DW-1:0]   w_d2;
    logic signed [PW-1:0]   w_y_rnd;
    logic signed [PW-1:0]   w_y_sat;

    assign w_in_idx = CH_W'(i_channel);
    assign w_in_ok  = (int'(i_channel) < CHANNELS);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1   <= svf_pkg::A1_RST;
            r_a2   <= svf_pkg::A2_RST;
            r_a3   <= svf_pkg::A3_RST;
            r_gain <= svf_pkg::GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (svf_pkg::t_cfg_idx'(i_cfg_addr))
                svf_pkg::CFG_A1:   r_a1   <= i_cfg_data[svf_pkg::COEF_W-1:0];
                svf_pkg::CFG_A2:   r_a2   <= i_cfg_data[svf_pkg::COEF_W-1:0];
                svf_pkg::CFG_A3:   r_a3   <= i_cfg_data[svf_pkg::COEF_W-1:0];
                svf_pkg::CFG_GAIN: r_gain <= i_cfg_data[svf_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // shared multipliers: a takes s1 or v2, b takes v3
    always_comb begin
        w_ma = i_cmd.gain ? r_v2 : VW'(r_s1);
        if (i_cmd.mul1) begin
            w_mb = $signed({1'b0, r_a1});
            w_mc = $signed({1'b0, r_a2});
        end else if (i_cmd.mul2) begin
            w_mb = $signed({1'b0, r_a2});
            w_mc = $signed({1'b0, r_a3});
        end else begin
            w_mb = $signed({{(MW - svf_pkg::GAIN_W){1'b0}}, r_gain});
            w_mc = $signed({1'b0, r_a3});
        end
    end

    assign w_pa = w_ma * w_mb;
    assign w_pb = r_v3 * w_mc;

    // rounded sums for v1 and v2, then the integrator updates
    assign w_v1_sum = r_pa + r_pb + svf_pkg::RND_COEF;
    assign w_v2_sum = r_pa + r_pb + (PW'(r_s2) <<< svf_pkg::COEF_FRAC) + svf_pkg::RND_COEF;
    assign w_d1     = (DW'(r_v1) <<< 1) - DW'(r_s1);
    assign w_d2     = (DW'(r_v2) <<< 1) - DW'(r_s2);

    // output rounding and saturation
    assign w_y_rnd = (r_pa + svf_pkg::RND_GAIN) >>> svf_pkg::GAIN_FRAC;
    always_comb begin
        if (w_y_rnd > Y_HI) begin
            w_y_sat = Y_HI;
        end else if (w_y_rnd < Y_LO) begin
            w_y_sat = Y_LO;
        end else begin
            w_y_sat = w_y_rnd;
        end
    end

    // sample working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx <= w_in_idx;
            r_ok  <= w_in_ok;
            r_ch  <= i_channel;
            r_s1  <= r_int1[w_in_idx];
            r_s2  <= r_int2[w_in_idx];
            r_v3  <= V3_W'(i_sample) - V3_W'(r_int2[w_in_idx]);
        end
        if (i_cmd.mul1 || i_cmd.mul2 || i_cmd.gain) begin
            r_pa <= PW'(w_pa);
        end
        if (i_cmd.mul1 || i_cmd.mul2) begin
            r_pb <= PW'(w_pb);
        end
        if (i_cmd.mul2) begin
            r_v1 <= VW'(w_v1_sum >>> svf_pkg::COEF_FRAC);
        end
        if (i_cmd.sum) begin
            r_v2 <= VW'(w_v2_sum >>> svf_pkg::COEF_FRAC);
        end
    end

    // integrator state update, skipped for a channel out of range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_int1[c] <= '0;
                r_int2[c] <= '0;
            end
        end else begin
            if (i_cmd.sum && r_ok) begin
                r_int1[r_idx] <= svf_pkg::sat_state(w_d1);
            end
            if (i_cmd.gain && r_ok) begin
                r_int2[r_idx] <= svf_pkg::sat_state(w_d2);
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_sample <= r_ok ? SAMPLE_BITS'(w_y_sat) : '0;
            r_out_ch     <= r_ch;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_sample        = r_out_sample;
    assign o_channel       = r_out_ch;

endmodule

/* src/svf_lowpass_filter_core.sv */
// a sample taken in idle passes through the states mul1, mul2, sum, gain and out;
// a new sample is taken only once the last one has gone to the output register; the
// two shared multipliers make two passes over the state products, then one pass
// for the gain product, each behind the previous result
// reset: clears both integrators of every channel, loads the default
// coefficients and gain, and empties the output register
module svf_lowpass_filter_core #(
    parameter int CHANNELS    = svf_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = svf_pkg::SAMPLE_BITS_DEF,
    parameter int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [TDATA_W-1:0]                 s_axis_tdata,   // in_sample, zero pad
    input  logic                               s_axis_tuser,   // in_channel
    // output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [TDATA_W-1:0]                 m_axis_tdata,   // out_sample, zero pad
    output logic                               m_axis_tuser,   // out_channel
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [svf_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [svf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    svf_pkg::t_cmd          w_cmd;
    svf_pkg::t_stat         w_stat;
    logic [SAMPLE_BITS-1:0] w_out_sample;

    // sequencer
    svf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // filter arithmetic, state and output register
    svf_dp #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_channel   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_sample    (w_out_sample),
        .o_channel   (m_axis_tuser)
    );

    assign m_axis_tdata = TDATA_W'(w_out_sample);

    // one sample at a time: no new transaction right after one is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a sample is in flight");

    // second product pass always follows the first
    a_pass_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mul2 |-> $past(w_cmd.mul1))
        else $error("second product pass without first");

    // a channel without state gives a zero sample
    a_bad_channel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (int'(m_axis_tuser) >= CHANNELS) |-> (w_out_sample == '0))
        else $error("nonzero sample for channel out of range");

    // output load only when the output register can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten");

endmodule

/* tb/sv/svf_lowpass_checker.sv */
module svf_lowpass_checker #(
    parameter int CHANNELS    = svf_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = svf_pkg::SAMPLE_BITS_DEF,
    parameter int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [TDATA_W-1:0]             i_in_data,    // in_sample, zero pad
    input  logic                           i_in_user,    // in_channel
    // output channel
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [TDATA_W-1:0]             i_out_data,   // out_sample, zero pad
    input  logic                           i_out_user,   // out_channel
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [svf_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [svf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // status to the top
    output int                             o_errors,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import svf_pkg::*;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct {
        t_sample smp;
        logic    ch;
    } t_filtered;

    // shadow copy of the filter state and registers
    logic signed [STATE_W-1:0] integ_one [CHANNELS];
    logic signed [STATE_W-1:0] integ_two [CHANNELS];
    logic [COEF_W-1:0]         a1_q;
    logic [COEF_W-1:0]         a2_q;
    logic [COEF_W-1:0]         a3_q;
    logic [GAIN_W-1:0]         gain_q;

    t_filtered filtered_q [$];
    int        err_cnt;

    // round half up, then drop the fraction bits
    function automatic longint round_shift(input longint v, input int sh);
        longint t;
        t = v + (longint'(1) <<< (sh - 1));
        return t >>> sh;
    endfunction

    function automatic longint clamp_signed(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // one trapezoidal svf step on a channel, returns the gained low-pass output
    function automatic t_sample lowpass_step(input logic ch, input t_sample x);
        longint s1;
        longint s2;
        longint v1;
        longint v2;
        longint v3;
        longint y;
        if (int'(ch) >= CHANNELS) begin
            return '0;
        end
        s1 = longint'(integ_one[ch]);
        s2 = longint'(integ_two[ch]);
        v3 = longint'(x) - s2;
        v1 = round_shift(longint'(a1_q) * s1 + longint'(a2_q) * v3, COEF_FRAC);
        v2 = s2 + round_shift(longint'(a2_q) * s1 + longint'(a3_q) * v3, COEF_FRAC);
        integ_one[ch] = STATE_W'(clamp_signed(2 * v1 - s1, STATE_W));
        integ_two[ch] = STATE_W'(clamp_signed(2 * v2 - s2, STATE_W));
        y = clamp_signed(round_shift(v2 * longint'(gain_q), GAIN_FRAC), SAMPLE_BITS);
        return SAMPLE_BITS'(y);
    endfunction

    always @(posedge i_clk) begin
        t_filtered item;
        t_filtered want;
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                integ_one[c] = '0;
                integ_two[c] = '0;
            end
            a1_q   = A1_RST;
            a2_q   = A2_RST;
            a3_q   = A3_RST;
            gain_q = GAIN_RST;
            filtered_q.delete();
        end else begin
            // accepted input transaction: predict its result
            if (i_in_valid && i_in_ready) begin
                item.ch  = i_in_user;
                item.smp = lowpass_step(i_in_user, t_sample'(i_in_data[SAMPLE_BITS-1:0]));
                filtered_q.push_back(item);
            end
            // accepted output transaction: compare with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (filtered_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected output transaction, expected none, %s %h %s %0d",
                             $realtime, "actual sample", i_out_data, "channel", i_out_user);
                end else begin
                    want = filtered_q.pop_front();
                    if (i_out_data !== TDATA_W'($unsigned(want.smp))) begin
                        err_cnt++;
                        $display("%0t: out_sample mismatch, expected %h actual %h",
                                 $realtime, TDATA_W'($unsigned(want.smp)), i_out_data);
                    end
                    if (i_out_user !== want.ch) begin
                        err_cnt++;
                        $display("%0t: out_channel mismatch, expected %0d actual %0d",
                                 $realtime, want.ch, i_out_user);
                    end
                end
            end
            // register writes take effect for later samples
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_A1:   a1_q   = i_cfg_data[COEF_W-1:0];
                    CFG_A2:   a2_q   = i_cfg_data[COEF_W-1:0];
                    CFG_A3:   a3_q   = i_cfg_data[COEF_W-1:0];
                    CFG_GAIN: gain_q = i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
        end
        o_errors  <= err_cnt;
        o_pending <= filtered_q.size();
    end

endmodule

/* tb/sv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import svf_pkg::*;

    localparam int  SBITS      = SAMPLE_BITS_DEF;
    localparam int  TDW        = ((SBITS + 7) / 8) * 8;
    localparam int  PHASES     = 12;
    localparam int  PHASE_ITEMS = 150;
    localparam longint CYCLE_LIMIT = 1000000;
    localparam logic [COEF_W-1:0] COEF_ONE = 23'd4194304;
    localparam logic [COEF_W-1:0] COEF_MAX = 23'h7FFFFF;
    localparam logic [GAIN_W-1:0] GAIN_MAX = 20'hFFFFF;
    localparam logic signed [SBITS-1:0] SMP_MAX = 24'sh7FFFFF;
    localparam logic signed [SBITS-1:0] SMP_MIN = 24'sh800000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [TDW-1:0]        s_axis_tdata;   // in_sample, zero pad
    logic                  s_axis_tuser;   // in_channel
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [TDW-1:0]        m_axis_tdata;   // out_sample, zero pad
    logic                  m_axis_tuser;   // out_channel
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int     err_total;
    int     pending_cnt;
    longint cycle_cnt;
    logic   quiet;

    svf_lowpass_filter_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    svf_lowpass_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (err_total),
        .o_pending   (pending_cnt)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // output side back-pressure
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        forever begin
            stall = idle_len();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // one input transaction; valid stays high into the next one when no gap follows
    task automatic send_sample(input logic signed [SBITS-1:0] smp, input logic ch);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDW'($unsigned(smp));
        s_axis_tuser  <= ch;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop sending and wait for every prediction to be matched
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // write all four registers on consecutive edges
    task automatic load_regs(input logic [COEF_W-1:0] a1, input logic [COEF_W-1:0] a2,
                             input logic [COEF_W-1:0] a3, input logic [GAIN_W-1:0] gain);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_A1;
        i_cfg_data <= a1;
        @(posedge i_clk);
        i_cfg_addr <= CFG_A2;
        i_cfg_data <= a2;
        @(posedge i_clk);
        i_cfg_addr <= CFG_A3;
        i_cfg_data <= a3;
        @(posedge i_clk);
        i_cfg_addr <= CFG_GAIN;
        i_cfg_data <= CFG_DATA_W'(gain);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [COEF_W-1:0] to_q22(input real v);
        real s;
        s = v * 4194304.0;
        if (s > 8388607.0) begin
            return COEF_MAX;
        end
        return COEF_W'(longint'(s));
    endfunction

    // pick a register setting for a random phase
    task automatic random_regs();
        int   r;
        real  g;
        real  k;
        real  a1;
        logic [GAIN_W-1:0] gain;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0) begin
            gain = GAIN_W'($urandom());
        end else begin
            gain = GAIN_W'($urandom_range(0, 196608));
        end
        if (r < 65) begin
            // coefficients of a real filter design
            g  = $urandom_range(1, 4000) / 1000.0;
            k  = $urandom_range(0, 2000) / 1000.0;
            a1 = 1.0 / (1.0 + g * (g + k));
            load_regs(to_q22(a1), to_q22(g * a1), to_q22(g * g * a1), gain);
        end else if (r < 85) begin
            load_regs(COEF_W'($urandom()), COEF_W'($urandom()), COEF_W'($urandom()), gain);
        end else begin
            load_regs($urandom_range(0, 1) ? COEF_MAX : '0, $urandom_range(0, 1) ? COEF_ONE : '0,
                      $urandom_range(0, 1) ? COEF_MAX : COEF_ONE,
                      $urandom_range(0, 1) ? GAIN_MAX : '0);
        end
    endtask

    function automatic logic signed [SBITS-1:0] pick_sample(input int mode);
        case (mode)
            0: return SBITS'($urandom());
            1: return SBITS'($signed($urandom_range(0, 2047)) - 1024);
            2: return $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
            default: return SBITS'($signed($urandom_range(0, 131071)) - 65536);
        endcase
    endfunction

    // stimulus
    initial begin
        int sent;
        int burst;
        int mode;
        logic ch;
        logic fixed_ch;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= CFG_A1;
        i_cfg_data    <= '0;
        quiet          = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default registers: field extremes on both channels
        send_sample('0, 1'b0);
        send_sample(SMP_MAX, 1'b0);
        send_sample(SMP_MIN, 1'b1);
        send_sample(24'sd1, 1'b1);
        send_sample(-24'sd1, 1'b0);
        send_sample(SMP_MAX, 1'b1);
        send_sample(SMP_MIN, 1'b0);
        drain();

        // coefficients above unity and maximum gain: state and output saturation
        load_regs(COEF_MAX, COEF_MAX, COEF_MAX, GAIN_MAX);
        repeat (4) send_sample(SMP_MAX, 1'b0);
        repeat (4) send_sample(SMP_MIN, 1'b1);
        send_sample(SMP_MIN, 1'b0);
        send_sample(SMP_MAX, 1'b1);
        drain();

        // everything zero
        load_regs('0, '0, '0, '0);
        send_sample(SMP_MAX, 1'b0);
        send_sample(SMP_MIN, 1'b1);
        send_sample(24'sd12345, 1'b0);
        drain();

        // random phases, the first with unity coefficients and maximum gain
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                load_regs(COEF_ONE, COEF_ONE, COEF_ONE, GAIN_MAX);
            end else begin
                random_regs();
            end
            quiet = (ph % 4 == 3);
            sent  = 0;
            while (sent < PHASE_ITEMS) begin
                burst    = $urandom_range(4, 40);
                mode     = $urandom_range(0, 9) < 5 ? 0 : $urandom_range(1, 3);
                fixed_ch = $urandom_range(0, 3) == 0;
                ch       = 1'($urandom_range(0, 1));
                for (int i = 0; i < burst && sent < PHASE_ITEMS; i++) begin
                    send_sample(pick_sample(mode), fixed_ch ? ch : 1'($urandom_range(0, 1)));
                    sent++;
                end
            end
            quiet = 1'b0;
            drain();
        end

        if (err_total == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* svf_lowpass_filter_core.f */
src/svf_pkg.sv
src/svf_ctrl.sv
src/svf_dp.sv
src/svf_lowpass_filter_core.sv
tb/sv/svf_lowpass_checker.sv
tb/sv/tb.sv
